// ----- rtl/core/rpm_pkg.sv -----
// package for the resolution peak merger: field widths, fsm states,
// command and status structs shared by controller and datapath
// no dependencies
package rpm_pkg;

    localparam int MASS_W      = 40;
    localparam int ABUN_W      = 32;
    localparam int ID_W        = 8;
    localparam int RP_W        = 24;
    localparam int MASS_LO_W   = 20;
    localparam int DEF_MAX_PEAKS = 64;
    localparam logic [RP_W-1:0] RP_RESET = 24'd100000;

    typedef enum logic [4:0] {
        S_LOAD, S_FIND_GO, S_FIND, S_PICK, S_HALF_GO, S_HALF, S_WIN,
        S_MERGE_GO, S_MERGE, S_MEAN_GO, S_MEAN, S_STORE,
        S_SEL_GO, S_SEL, S_ORD, S_OLOAD, S_OUT, S_CLEAR
    } t_state;

    typedef enum logic [1:0] {SCAN_FIND, SCAN_MERGE, SCAN_SEL} t_scan;
    typedef enum logic {DIV_HALF, DIV_MEAN} t_div;

    typedef struct packed {
        logic  load;
        logic  scan_start;
        t_scan scan_mode;
        logic  div_start;
        t_div  div_mode;
        logic  set_window;
        logic  store;
        logic  out_load;
        logic  clear;
    } t_cmd;

    typedef struct packed {
        logic scan_busy;
        logic div_busy;
        logic found;
        logic sel_found;
        logic out_busy;
    } t_sts;

endpackage

// ----- rtl/core/resolution_peak_merger.sv -----
// top level of the resolution peak merger: controller plus datapath
// depends on rpm_pkg, rpm_ctrl, rpm_dp
//
// channel   direction  handshake                    payload
// peak in   in         i_valid / o_ready            i_peak_mass, i_peak_abundance,
//                                                   i_source_id, i_last_in
// merged    out        o_valid / i_ready            o_merged_mass, o_merged_abundance,
//                                                   o_merged_id, o_last_out
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_resolving_power
//
// a plain request is stored; a request with last_in starts the merge
// each merged peak costs a max scan, a restoring divide (78 steps) for the
// window, a merge scan, a second divide for the mean and a store
// each emitted peak costs a min scan plus the hand-out on the output;
// one more max scan and min scan and a clear close the list
// input is not accepted during merge and emit;
// output stalls hold the block
// reset (synchronous, active low) empties the list and restores resolving power
module resolution_peak_merger import rpm_pkg::*; #(
    parameter int MAX_PEAKS = DEF_MAX_PEAKS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [MASS_W-1:0] i_peak_mass,
    input  logic [ABUN_W-1:0] i_peak_abundance,
    input  logic [ID_W-1:0]   i_source_id,
    input  logic              i_last_in,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [MASS_W-1:0] o_merged_mass,
    output logic [ABUN_W-1:0] o_merged_abundance,
    output logic [ID_W-1:0]   o_merged_id,
    output logic              o_last_out,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [RP_W-1:0]   i_cfg_resolving_power
);

    t_cmd w_cmd;
    t_sts w_sts;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    rpm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_last_in (i_last_in),
        .i_sts     (w_sts),
        .o_ready   (o_ready),
        .o_cmd     (w_cmd)
    );

    rpm_dp #(.MAX_PEAKS(MAX_PEAKS)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_data         (i_cfg_resolving_power),
        .i_peak_mass        (i_peak_mass),
        .i_peak_abundance   (i_peak_abundance),
        .i_source_id        (i_source_id),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_merged_mass      (o_merged_mass),
        .o_merged_abundance (o_merged_abundance),
        .o_merged_id        (o_merged_id),
        .o_last_out         (o_last_out)
    );

endmodule

// ----- rtl/core/rpm_ctrl.sv -----
// sequencing fsm of the resolution peak merger
// depends on rpm_pkg
module rpm_ctrl import rpm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_last_in,
    input  t_sts i_sts,
    output logic o_ready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last_in) n_state = S_FIND_GO;
                end
            end
            S_FIND_GO: begin
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_mode  = SCAN_FIND;
                n_state = S_FIND;
            end
            S_FIND: begin
                if (!i_sts.scan_busy) n_state = i_sts.found ? S_PICK : S_SEL_GO;
            end
            S_PICK: n_state = S_HALF_GO;
            S_HALF_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_mode  = DIV_HALF;
                n_state = S_HALF;
            end
            S_HALF: begin
                if (!i_sts.div_busy) n_state = S_WIN;
            end
            S_WIN: begin
                o_cmd.set_window = 1'b1;
                n_state = S_MERGE_GO;
            end
            S_MERGE_GO: begin
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_mode  = SCAN_MERGE;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (!i_sts.scan_busy) n_state = S_MEAN_GO;
            end
            S_MEAN_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_mode  = DIV_MEAN;
                n_state = S_MEAN;
            end
            S_MEAN: begin
                if (!i_sts.div_busy) n_state = S_STORE;
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state = S_FIND_GO;
            end
            S_SEL_GO: begin
                o_cmd.scan_start = 1'b1;
                o_cmd.scan_mode  = SCAN_SEL;
                n_state = S_SEL;
            end
            S_SEL: begin
                if (!i_sts.scan_busy) n_state = i_sts.sel_found ? S_ORD : S_CLEAR;
            end
            S_ORD: n_state = S_OLOAD;
            S_OLOAD: begin
                o_cmd.out_load = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_sts.out_busy) n_state = S_SEL_GO;
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

endmodule

// ----- rtl/core/rpm_dp.sv -----
// datapath of the resolution peak merger: peak and merged stores, scanner,
// multiply-accumulate pipe, shared restoring divider, output register
// depends on rpm_pkg
module rpm_dp import rpm_pkg::*; #(
    parameter int MAX_PEAKS = DEF_MAX_PEAKS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_cfg_valid,
    input  logic [RP_W-1:0]   i_cfg_data,
    input  logic [MASS_W-1:0] i_peak_mass,
    input  logic [ABUN_W-1:0] i_peak_abundance,
    input  logic [ID_W-1:0]   i_source_id,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [MASS_W-1:0] o_merged_mass,
    output logic [ABUN_W-1:0] o_merged_abundance,
    output logic [ID_W-1:0]   o_merged_id,
    output logic              o_last_out
);

    localparam int IDX_W  = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int CNT_W  = $clog2(MAX_PEAKS + 1);
    localparam int SUM_W  = ABUN_W + IDX_W;
    localparam int ACC_W  = MASS_W + ABUN_W + IDX_W;
    localparam int DCNT_W = $clog2(ACC_W + 1);
    localparam int HI_W   = MASS_W - MASS_LO_W;
    localparam int P_W    = MASS_LO_W + ABUN_W;
    localparam int Q_W    = HI_W + ABUN_W;

    // configuration
    logic [RP_W-1:0] r_rp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp <= RP_RESET;
        end else if (i_cfg_valid) begin
            r_rp <= (i_cfg_data == '0) ? RP_W'(1) : i_cfg_data;
        end
    end

    // stores
    logic [MASS_W-1:0] mem_mass [MAX_PEAKS];
    logic [ABUN_W-1:0] mem_ab   [MAX_PEAKS];
    logic [ID_W-1:0]   mem_id   [MAX_PEAKS];
    logic [MASS_W-1:0] mrg_mass [MAX_PEAKS];
    logic [ABUN_W-1:0] mrg_ab   [MAX_PEAKS];
    logic [ID_W-1:0]   mrg_id   [MAX_PEAKS];

    logic [MAX_PEAKS-1:0] r_present, r_emitted;
    logic [CNT_W-1:0]     r_count, r_mcount, r_ecount;

    // scanner
    t_scan            r_mode;
    logic             r_act, r_v1, r_v2;
    logic [CNT_W-1:0] r_i;
    logic [IDX_W-1:0] r_idx1;
    logic [CNT_W-1:0] w_limit;
    logic [IDX_W-1:0] w_pk_addr, w_mg_addr;

    logic [MASS_W-1:0] r_rd_mass, r_rdm_mass;
    logic [ABUN_W-1:0] r_rd_ab,   r_rdm_ab;
    logic [ID_W-1:0]   r_rd_id,   r_rdm_id;

    logic              r_found, r_sel_found;
    logic [IDX_W-1:0]  r_best, r_sel;
    logic [ABUN_W-1:0] r_best_ab;
    logic [MASS_W-1:0] r_sel_mass;

    logic [MASS_W-1:0] r_m;
    logic [MASS_W:0]   r_lo, r_hi;

    logic [P_W-1:0]    r_p0;
    logic [Q_W-1:0]    r_p1;
    logic [ACC_W-1:0]  r_acc;
    logic [SUM_W-1:0]  r_sum;
    logic              r_got;
    logic [ABUN_W-1:0] r_top_ab;
    logic [ID_W-1:0]   r_top_id;

    logic w_take;

    assign w_limit   = (r_mode == SCAN_SEL) ? r_mcount : r_count;
    assign w_pk_addr = r_act ? r_i[IDX_W-1:0] : r_best;
    assign w_mg_addr = r_act ? r_i[IDX_W-1:0] : r_sel;

    // peak store: write on load, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && r_count < CNT_W'(MAX_PEAKS)) begin
            mem_mass[r_count[IDX_W-1:0]] <= i_peak_mass;
            mem_ab[r_count[IDX_W-1:0]]   <= i_peak_abundance;
            mem_id[r_count[IDX_W-1:0]]   <= i_source_id;
        end
        r_rd_mass <= mem_mass[w_pk_addr];
        r_rd_ab   <= mem_ab[w_pk_addr];
        r_rd_id   <= mem_id[w_pk_addr];
    end

    // divider
    logic              r_dbusy;
    logic [DCNT_W-1:0] r_dcnt;
    logic [ACC_W-1:0]  r_quo;
    logic [SUM_W-1:0]  r_rem, r_dvs;
    logic [SUM_W:0]    w_trial;
    logic              w_ge;
    logic [MASS_W-1:0] w_half, w_mean;
    logic [ABUN_W-1:0] w_sat;

    assign w_trial = {r_rem, r_quo[ACC_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_half  = {1'b0, r_quo[MASS_W-1:1]};
    assign w_mean  = (r_sum == '0) ? '0 : r_quo[MASS_W-1:0];
    assign w_sat   = (r_sum > SUM_W'({ABUN_W{1'b1}})) ? {ABUN_W{1'b1}} : r_sum[ABUN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_dcnt  <= '0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1;
            r_dcnt  <= DCNT_W'(ACC_W);
        end else if (r_dbusy) begin
            r_dcnt  <= r_dcnt - 1'b1;
            if (r_dcnt == DCNT_W'(1)) r_dbusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            if (i_cmd.div_mode == DIV_HALF) begin
                r_quo <= ACC_W'(r_rd_mass);
                r_dvs <= SUM_W'(r_rp);
                r_m   <= r_rd_mass;
            end else begin
                r_quo <= r_acc;
                r_dvs <= r_sum;
            end
        end else if (r_dbusy) begin
            r_rem <= w_ge ? SUM_W'(w_trial - {1'b0, r_dvs}) : w_trial[SUM_W-1:0];
            r_quo <= {r_quo[ACC_W-2:0], w_ge};
        end
        if (i_cmd.set_window) begin
            r_lo <= {1'b0, r_m - w_half};
            r_hi <= {1'b0, r_m} + {1'b0, w_half};
        end
    end

    // scan control and per-mode evaluation
    logic w_in_win, w_member;
    assign w_in_win = ({1'b0, r_rd_mass} >= r_lo) && ({1'b0, r_rd_mass} < r_hi);
    assign w_member = r_v1 && (r_mode == SCAN_MERGE) && r_present[r_idx1]
                      && ((r_idx1 == r_best) || w_in_win);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_i   <= '0;
            r_mode <= SCAN_FIND;
        end else begin
            r_v1 <= r_act && (r_i < w_limit);
            r_v2 <= w_member;
            if (i_cmd.scan_start) begin
                r_act  <= 1'b1;
                r_i    <= '0;
                r_mode <= i_cmd.scan_mode;
            end else if (r_act) begin
                if (r_i >= w_limit) r_act <= 1'b0;
                else r_i <= r_i + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= r_i[IDX_W-1:0];
        if (i_cmd.scan_start) begin
            r_found     <= 1'b0;
            r_sel_found <= 1'b0;
            r_acc       <= '0;
            r_sum       <= '0;
            r_got       <= 1'b0;
        end else begin
            if (r_v1 && r_mode == SCAN_FIND && r_present[r_idx1]
                && (!r_found || r_rd_ab > r_best_ab)) begin
                r_found   <= 1'b1;
                r_best    <= r_idx1;
                r_best_ab <= r_rd_ab;
            end
            if (r_v1 && r_mode == SCAN_SEL && !r_emitted[r_idx1]
                && (!r_sel_found || r_rdm_mass <= r_sel_mass)) begin
                r_sel_found <= 1'b1;
                r_sel       <= r_idx1;
                r_sel_mass  <= r_rdm_mass;
            end
            if (w_member) begin
                r_p0  <= r_rd_mass[MASS_LO_W-1:0] * r_rd_ab;
                r_p1  <= r_rd_mass[MASS_W-1:MASS_LO_W] * r_rd_ab;
                r_sum <= r_sum + SUM_W'(r_rd_ab);
                if (!r_got || r_rd_ab >= r_top_ab) begin
                    r_got    <= 1'b1;
                    r_top_ab <= r_rd_ab;
                    r_top_id <= r_rd_id;
                end
            end
            if (r_v2) begin
                r_acc <= r_acc + ACC_W'(r_p0) + (ACC_W'(r_p1) << MASS_LO_W);
            end
        end
    end

    // merged store: append on store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            mrg_mass[r_mcount[IDX_W-1:0]] <= w_mean;
            mrg_ab[r_mcount[IDX_W-1:0]]   <= w_sat;
            mrg_id[r_mcount[IDX_W-1:0]]   <= r_top_id;
        end
        r_rdm_mass <= mrg_mass[w_mg_addr];
        r_rdm_ab   <= mrg_ab[w_mg_addr];
        r_rdm_id   <= mrg_id[w_mg_addr];
    end

    // flags and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_present <= '0;
            r_emitted <= '0;
            r_count   <= '0;
            r_mcount  <= '0;
            r_ecount  <= '0;
        end else begin
            if (i_cmd.load && r_count < CNT_W'(MAX_PEAKS)) begin
                r_present[r_count[IDX_W-1:0]] <= 1'b1;
                r_count <= r_count + 1'b1;
            end
            if (w_member) r_present[r_idx1] <= 1'b0;
            if (i_cmd.store) r_mcount <= r_mcount + 1'b1;
            if (i_cmd.out_load) begin
                r_emitted[r_sel] <= 1'b1;
                r_ecount <= r_ecount + 1'b1;
            end
        end
    end

    // output register
    assign w_take = o_valid && i_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_valid <= 1'b1;
        end else if (w_take) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_merged_mass      <= r_rdm_mass;
            o_merged_abundance <= r_rdm_ab;
            o_merged_id        <= r_rdm_id;
            o_last_out         <= (r_ecount + 1'b1) == r_mcount;
        end
    end

    assign o_sts.scan_busy = r_act | r_v1 | r_v2;
    assign o_sts.div_busy  = r_dbusy;
    assign o_sts.found     = r_found;
    assign o_sts.sel_found = r_sel_found;
    assign o_sts.out_busy  = o_valid;

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !r_dbusy)
        else $error("divider restarted while busy");
    a_scan_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_start |-> !(r_act | r_v1 | r_v2))
        else $error("scan restarted while busy");
    a_mcount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mcount <= r_count)
        else $error("more merged peaks than loaded peaks");
    a_out_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !o_valid)
        else $error("output overwritten before taken");

endmodule
